/* sv/qdar_pkg.sv */
// Shared types, constants and the phase transition decode for the quadrature decoder.
`timescale 1ns / 1ps

package qdar_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV_WHOLE,
      ST_SCALE_MICRO,
      ST_DIV_MICRO,
      ST_DONE
   } state_type;

   localparam int STEPS_WIDTH = 11;
   localparam int DELTA_WIDTH = 2;
   localparam int WHOLE_WIDTH = 25;
   localparam int MICRO_WIDTH = 21;
   localparam int MICRO_PROD_WIDTH = 31;

   localparam logic [STEPS_WIDTH-1:0] STEPS_RESET = 11'd24;
   localparam int DEG_FULL = 360;
   localparam logic [19:0] MICRO_SCALE = 20'd1000000;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   typedef logic signed [DELTA_WIDTH-1:0] delta_type;

   // Gray-code transition: previous phase in the high bits, new phase in the low bits
   function automatic delta_type step_lookup(input logic [1:0] prev, input logic [1:0] cur);
      logic [3:0] idx;
      delta_type  res;
      idx = {prev, cur};
      if (idx inside {4'b0001, 4'b0111, 4'b1110, 4'b1000}) begin
         res = 2'sb01;
      end else if (idx inside {4'b0010, 4'b0100, 4'b1101, 4'b1011}) begin
         res = 2'sb11;
      end else begin
         res = 2'sb00;
      end
      return res;
   endfunction

endpackage

/* sv/quadrature_decoder_angle_readout.sv */
// 4x quadrature decoder with saturating pulse counter and bit-serial angle readout.
// Pin samples and reads of an unsupported channel have their result beat registered
// directly, so it appears in the cycle after acceptance. A rotation read clears the counter
// and then runs two divisions through one restoring divider that retires one quotient bit
// per cycle over a DVW-bit word, DVW = max(COUNT_WIDTH+9, 31). The read passes through the
// scale, whole divide, micro scale and micro divide states to its result beat. A new beat
// is accepted whenever the block is idle and the output register is empty or being drained.
`timescale 1ns / 1ps

module quadrature_decoder_angle_readout #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // [1:0] phase_ab
   input  logic [1:0]                          req_tuser,   // [0] op, [1] rotation_channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [55:0]                         rsp_tdata,   // [1:0] step_delta, [2] moved,
                                                            // [27:3] degrees_whole,
                                                            // [48:28] degrees_micro
   output logic                                rsp_tuser,   // [0] status
   input  logic                                csr_wr_en,
   input  logic [qdar_pkg::STEPS_WIDTH-1:0]    csr_wr_data  // steps_per_rev
);
   import qdar_pkg::*;

   localparam int DVW  = (COUNT_WIDTH + 9 > MICRO_PROD_WIDTH) ? COUNT_WIDTH + 9
                                                             : MICRO_PROD_WIDTH;
   localparam int CNTW = $clog2(DVW);

   state_type                       state_ff, state_in;
   logic [STEPS_WIDTH-1:0]          spr_ff, spr_in;
   logic [1:0]                      phase_ff, phase_in;
   logic                            known_ff, known_in;
   logic signed [COUNT_WIDTH-1:0]   count_ff, count_in;

   logic                            neg_ff, neg_in;
   logic [COUNT_WIDTH-1:0]          mag_ff, mag_in;
   logic [STEPS_WIDTH-1:0]          div_ff, div_in;
   logic [STEPS_WIDTH-1:0]          rem_ff, rem_in;
   logic [DVW-1:0]                  dq_ff, dq_in;
   logic [DVW-1:0]                  quot_ff, quot_in;
   logic [CNTW-1:0]                 bit_ff, bit_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   delta_type                       delta_out_ff, delta_out_in;
   logic                            moved_out_ff, moved_out_in;
   logic signed [WHOLE_WIDTH-1:0]   whole_out_ff, whole_out_in;
   logic signed [MICRO_WIDTH-1:0]   micro_out_ff, micro_out_in;
   logic                            status_out_ff, status_out_in;

   logic                            req_fire;
   logic                            out_free;
   logic                            req_op;
   logic                            req_rot;
   logic [1:0]                      req_phase;
   logic                            read_rot;
   delta_type                       delta;
   logic signed [COUNT_WIDTH:0]     sum;
   logic [STEPS_WIDTH:0]            shifted;
   logic [STEPS_WIDTH+1:0]          diff;
   logic                            take;
   logic [STEPS_WIDTH-1:0]          rem_step;
   logic [DVW-1:0]                  dq_step;
   logic [MICRO_PROD_WIDTH-1:0]     micro_prod;
   logic [DVW-1:0]                  scaled;
   logic                            load_done;

   assign req_op    = req_tuser[0];
   assign req_rot   = req_tuser[1];
   assign req_phase = req_tdata[1:0];
   assign out_free  = ~rsp_valid_ff | rsp_tready;
   assign req_fire  = req_tvalid & req_tready;
   assign read_rot  = req_fire & (req_op == OP_READ) & req_rot;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (read_rot) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:       state_in = ST_DIV_WHOLE;
         ST_DIV_WHOLE: begin
            if (bit_ff == '0) begin
               state_in = ST_SCALE_MICRO;
            end
         end
         ST_SCALE_MICRO: state_in = ST_DIV_MICRO;
         ST_DIV_MICRO: begin
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:        state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_tready = 1'b0;
      load_done  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = out_free;
         ST_DONE: load_done  = out_free;
         default: begin
            req_tready = 1'b0;
            load_done  = 1'b0;
         end
      endcase
   end

   // Decode, counter add, one restoring divide step and the scaling products
   always_comb begin
      delta = known_ff ? step_lookup(phase_ff, req_phase) : delta_type'(2'sb00);
      sum   = {count_ff[COUNT_WIDTH-1], count_ff} + (COUNT_WIDTH+1)'(delta);

      shifted  = {rem_ff, dq_ff[DVW-1]};
      diff     = {1'b0, shifted} - {2'b00, div_ff};
      take     = ~diff[STEPS_WIDTH+1];
      rem_step = take ? diff[STEPS_WIDTH-1:0] : shifted[STEPS_WIDTH-1:0];
      dq_step  = {dq_ff[DVW-2:0], take};

      micro_prod = MICRO_PROD_WIDTH'(rem_ff) * MICRO_PROD_WIDTH'(MICRO_SCALE);
      scaled     = DVW'(mag_ff) * DVW'(DEG_FULL);
   end

   // Register next values
   always_comb begin
      spr_in   = csr_wr_en ? csr_wr_data : spr_ff;
      phase_in = phase_ff;
      known_in = known_ff;
      count_in = count_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      dq_in    = dq_ff;
      quot_in  = quot_ff;
      bit_in   = bit_ff;

      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      delta_out_in  = delta_out_ff;
      moved_out_in  = moved_out_ff;
      whole_out_in  = whole_out_ff;
      micro_out_in  = micro_out_ff;
      status_out_in = status_out_ff;

      if (req_fire) begin
         if (req_op == OP_SAMPLE) begin
            phase_in = req_phase;
            known_in = 1'b1;
            if (known_ff) begin
               // clamp on overflow of the signed counter
               if (sum[COUNT_WIDTH] != sum[COUNT_WIDTH-1]) begin
                  count_in = sum[COUNT_WIDTH] ? {1'b1, {(COUNT_WIDTH-1){1'b0}}}
                                              : {1'b0, {(COUNT_WIDTH-1){1'b1}}};
               end else begin
                  count_in = sum[COUNT_WIDTH-1:0];
               end
            end
            rsp_valid_in  = 1'b1;
            delta_out_in  = delta;
            moved_out_in  = (delta != 2'sb00);
            whole_out_in  = '0;
            micro_out_in  = '0;
            status_out_in = STATUS_OK;
         end else if (!req_rot) begin
            rsp_valid_in  = 1'b1;
            delta_out_in  = 2'sb00;
            moved_out_in  = 1'b0;
            whole_out_in  = '0;
            micro_out_in  = '0;
            status_out_in = STATUS_UNSUPPORTED;
         end else begin
            // take the magnitude, latch the divisor and clear the counter
            neg_in   = count_ff[COUNT_WIDTH-1];
            mag_in   = count_ff[COUNT_WIDTH-1] ? COUNT_WIDTH'(-count_ff) : count_ff;
            div_in   = (spr_ff == '0) ? STEPS_WIDTH'(1) : spr_ff;
            count_in = '0;
         end
      end

      case (state_ff)
         ST_SCALE: begin
            dq_in  = scaled;
            rem_in = '0;
            bit_in = CNTW'(DVW - 1);
         end
         ST_DIV_WHOLE, ST_DIV_MICRO: begin
            dq_in  = dq_step;
            rem_in = rem_step;
            bit_in = bit_ff - CNTW'(1);
         end
         ST_SCALE_MICRO: begin
            quot_in = dq_ff;
            dq_in   = DVW'(micro_prod);
            rem_in  = '0;
            bit_in  = CNTW'(DVW - 1);
         end
         default: begin
            bit_in = bit_ff;
         end
      endcase

      if (load_done) begin
         rsp_valid_in  = 1'b1;
         delta_out_in  = 2'sb00;
         moved_out_in  = 1'b0;
         whole_out_in  = neg_ff ? -quot_ff[WHOLE_WIDTH-1:0] : quot_ff[WHOLE_WIDTH-1:0];
         micro_out_in  = neg_ff ? -dq_ff[MICRO_WIDTH-1:0] : dq_ff[MICRO_WIDTH-1:0];
         status_out_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         spr_ff       <= STEPS_RESET;
         phase_ff     <= '0;
         known_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         spr_ff       <= spr_in;
         phase_ff     <= phase_in;
         known_ff     <= known_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff        <= neg_in;
      mag_ff        <= mag_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      quot_ff       <= quot_in;
      bit_ff        <= bit_in;
      delta_out_ff  <= delta_out_in;
      moved_out_ff  <= moved_out_in;
      whole_out_ff  <= whole_out_in;
      micro_out_ff  <= micro_out_in;
      status_out_ff <= status_out_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, micro_out_ff, whole_out_ff, moved_out_ff, delta_out_ff};
   assign rsp_tuser  = status_out_ff;

`ifndef SYNTH
   a_clear_on_read: assert property (@(posedge clock) disable iff (reset)
      read_rot |=> (count_ff == '0))
      else $error("counter not cleared after rotation read");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV_WHOLE || state_ff == ST_DIV_MICRO) |-> (rem_ff < div_ff))
      else $error("partial remainder reached the divisor");

   a_moved_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (moved_out_ff == (delta_out_ff != 2'sb00)))
      else $error("moved flag disagrees with step");

   a_micro_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (micro_out_ff <= 21'sd999999 && micro_out_ff >= -21'sd999999))
      else $error("millionths out of range");

   a_status_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_out_ff == STATUS_UNSUPPORTED) |->
         (whole_out_ff == '0 && micro_out_ff == '0 && delta_out_ff == 2'sb00))
      else $error("unsupported read carries data");
`endif

endmodule
